@@ src/spp_pkg.sv @@
// spp_pkg: shared widths, payload structs and controller/datapath command types
// for the spectral peak picker. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package spp_pkg;

  localparam int MAG_BITS  = 24;
  localparam int BIN_BITS  = 12;
  localparam int FRAC_BITS = 15;

  // remainder must hold twice the largest denominator
  localparam int REM_W = MAG_BITS + 3;
  // product of difference and quotient
  localparam int ACC_W = MAG_BITS + FRAC_BITS;

  typedef struct packed {
    logic [MAG_BITS-1:0] magnitude;
    logic                last_bin;
  } spp_in_t;

  typedef struct packed {
    logic        [BIN_BITS-1:0]  peak_index;
    logic signed [FRAC_BITS:0]   fraction_offset;
    logic        [MAG_BITS:0]    peak_level;
  } spp_out_t;

  typedef struct packed {
    logic accept;
    logic load;
    logic step;
    logic emit;
  } spp_cmd_t;

  typedef struct packed {
    logic peak;
  } spp_stat_t;

endpackage

`default_nettype wire

@@ src/spp_datapath.sv @@
// spp_datapath: threshold register, three-bin window, peak test, restoring
// divider with merged shift-add multiplier, and the result register. Uses spp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module spp_datapath import spp_pkg::*; (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                cfg_we,
  input  wire logic [MAG_BITS-1:0] cfg_data,
  input  wire spp_in_t             in_data,
  input  wire spp_cmd_t            cmd,
  output spp_stat_t                stat,
  output spp_out_t                 out_data
);

  localparam logic [BIN_BITS-1:0] BIN_MAX = {BIN_BITS{1'b1}};

  logic [MAG_BITS-1:0] peak_threshold;
  logic [MAG_BITS-1:0] older_magnitude;
  logic [MAG_BITS-1:0] middle_magnitude;
  logic [BIN_BITS-1:0] bin_count;
  logic                overrun;

  logic [REM_W-1:0]     div_rem;
  logic [REM_W-1:0]     div_den;
  logic [FRAC_BITS-1:0] div_quo;
  logic [ACC_W-1:0]     mul_acc;
  logic [MAG_BITS-1:0]  op_diff;
  logic [MAG_BITS-1:0]  op_mid;
  logic [BIN_BITS-1:0]  op_index;
  logic                 op_neg;

  logic                a_bigger;
  logic [MAG_BITS-1:0] diff;
  logic [MAG_BITS:0]   sum_ag;
  logic [MAG_BITS:0]   den_half;
  logic [REM_W-1:0]    den_full;
  logic [REM_W-1:0]    rem_shift;
  logic                q_bit;
  logic [FRAC_BITS:0]  quo_ext;

  always_comb begin
    a_bigger  = older_magnitude > in_data.magnitude;
    diff      = a_bigger ? (older_magnitude - in_data.magnitude)
                         : (in_data.magnitude - older_magnitude);
    sum_ag    = {1'b0, older_magnitude} + {1'b0, in_data.magnitude};
    // 2b - a - g, positive for any strict peak
    den_half  = {middle_magnitude, 1'b0} - sum_ag;
    den_full  = {1'b0, den_half, 1'b0};
    stat.peak = (bin_count >= BIN_BITS'(2)) && !overrun
              && (middle_magnitude > older_magnitude)
              && (middle_magnitude > in_data.magnitude)
              && (middle_magnitude > peak_threshold);
    rem_shift = {div_rem[REM_W-2:0], 1'b0};
    q_bit     = rem_shift >= div_den;
    quo_ext   = {1'b0, div_quo};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      peak_threshold   <= '0;
      older_magnitude  <= '0;
      middle_magnitude <= '0;
      bin_count        <= '0;
      overrun          <= 1'b0;
    end else begin
      if (cfg_we) begin
        peak_threshold <= cfg_data;
      end
      if (cmd.accept) begin
        if (in_data.last_bin) begin
          older_magnitude  <= '0;
          middle_magnitude <= '0;
          bin_count        <= '0;
          overrun          <= 1'b0;
        end else begin
          older_magnitude  <= middle_magnitude;
          middle_magnitude <= in_data.magnitude;
          if (bin_count == BIN_MAX) begin
            overrun <= 1'b1;
          end else begin
            bin_count <= bin_count + 1'b1;
          end
        end
      end
    end
  end

  // quotient bits come out msb first, so the product accumulates alongside
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      div_rem  <= {{(REM_W-MAG_BITS){1'b0}}, diff};
      div_den  <= den_full;
      div_quo  <= '0;
      mul_acc  <= '0;
      op_diff  <= diff;
      op_mid   <= middle_magnitude;
      op_index <= bin_count - 1'b1;
      op_neg   <= a_bigger;
    end else if (cmd.step) begin
      div_rem <= q_bit ? (rem_shift - div_den) : rem_shift;
      div_quo <= {div_quo[FRAC_BITS-2:0], q_bit};
      mul_acc <= {mul_acc[ACC_W-2:0], 1'b0}
               + (q_bit ? {{FRAC_BITS{1'b0}}, op_diff} : '0);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_data.peak_index      <= op_index;
      out_data.fraction_offset <= op_neg ? -$signed(quo_ext) : $signed(quo_ext);
      out_data.peak_level      <= {1'b0, op_mid}
                                + {3'b000, mul_acc[ACC_W-1:FRAC_BITS+2]};
    end
  end

endmodule

`default_nettype wire

@@ src/spp_ctrl.sv @@
// spp_ctrl: sequencer for the spectral peak picker; input stall, divider step
// count and output valid. Uses spp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module spp_ctrl import spp_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      in_valid,
  output logic           in_stall,
  output logic           out_valid,
  input  wire logic      out_stall,
  input  wire spp_stat_t stat,
  output spp_cmd_t       cmd
);

  localparam int CNT_W = $clog2(FRAC_BITS);
  localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(FRAC_BITS - 1);

  typedef enum logic [1:0] {ST_IDLE, ST_DIV, ST_FIN} state_t;

  state_t           state;
  logic [CNT_W-1:0] step_cnt;

  always_comb begin
    in_stall   = state != ST_IDLE;
    cmd.accept = in_valid && (state == ST_IDLE);
    cmd.load   = cmd.accept && stat.peak;
    cmd.step   = state == ST_DIV;
    cmd.emit   = (state == ST_FIN) && (!out_valid || !out_stall);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      step_cnt  <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.emit) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (cmd.load) begin
            state    <= ST_DIV;
            step_cnt <= '0;
          end
        end
        ST_DIV: begin
          if (step_cnt == LAST_STEP) begin
            state <= ST_FIN;
          end else begin
            step_cnt <= step_cnt + 1'b1;
          end
        end
        ST_FIN: begin
          if (cmd.emit) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  a_load_starts_div: assert property (@(posedge clk) disable iff (rst)
    cmd.load |=> (state == ST_DIV) && (step_cnt == '0))
    else $error("peak accepted but divider did not start");

  a_step_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIV) |-> (step_cnt <= LAST_STEP))
    else $error("divider step count out of range");

  a_fin_holds: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FIN) && !cmd.emit |=> (state == ST_FIN) && out_valid)
    else $error("finished result dropped while output busy");

  a_emit_shows: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |=> out_valid && (state == ST_IDLE))
    else $error("result beat not presented after emit");

endmodule

`default_nettype wire

@@ src/spectral_peak_picker_top.sv @@
// spectral_peak_picker_top: three-bin local maximum detector with parabolic
// offset and level interpolation. A bin that closes a peak loads the divider,
// which steps in ST_DIV and waits in ST_FIN until emit loads the result and
// out_valid. Throughput: one bin per cycle when no peak closes; a closing bin
// stalls input for the one-bit-per-cycle divider and while an earlier result
// waits on out_stall. Reset clears window, bin counter, threshold, out_valid.
`timescale 1ns / 1ps
`default_nettype none

module spectral_peak_picker_top import spp_pkg::*; (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                cfg_valid,
  output logic                     cfg_ready,
  input  wire logic [MAG_BITS-1:0] cfg_data,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire spp_in_t             in_data,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output spp_out_t                 out_data
);

  spp_cmd_t  cmd;
  spp_stat_t stat;

  // threshold writes are always taken
  assign cfg_ready = 1'b1;

  spp_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  spp_datapath u_datapath (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_valid && cfg_ready),
    .cfg_data (cfg_data),
    .in_data  (in_data),
    .cmd      (cmd),
    .stat     (stat),
    .out_data (out_data)
  );

endmodule

`default_nettype wire
